// File: rtl/fplw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fplw_pkg;

  // table store geometry
  localparam int TABLE_PAGES       = 8;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_W            = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int STORE_WORDS       = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int ADDR_W            = PAGE_W + IDX_W;

  // field widths
  localparam int WIDX_W   = 12;
  localparam int WORD_W   = 64;
  localparam int VA_W     = 64;
  localparam int PA_W     = 52;
  localparam int OFFSET_W = 12;
  localparam int ROOT_W   = 3;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ROOT = 1'b0;

  // command codes
  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_MAPPED       = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT  = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  // walk levels
  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef struct packed {
    logic                command;
    logic [WIDX_W-1:0]   word_index;
    logic [WORD_W-1:0]   write_data;
    logic [VA_W-1:0]     virtual_address;
  } in_item_t;

  typedef struct packed {
    logic [PA_W-1:0] physical_address;
    logic [1:0]      status;
    logic [1:0]      fault_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic write_en;
    logic start;
    logic step;
    logic load_walk;
    logic load_root;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic root_oob;
    logic walk_done;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// File: rtl/four_level_page_walk_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    handshake                 payload
// in         in_valid_i / in_ready_o   in_data_i   (command, word_index, write_data, va)
// out        out_valid_o / out_ready_i out_data_o  (physical_address, status, fault_level)
// config     psel/penable/pwrite/pready paddr, pwdata, prdata (root_table_page at 0x0)
//
// a write is stored in the table store in its accept cycle; a translate issues the top-level
// read in its accept cycle, then reads one entry per level as each comes out of the single
// read port of the table store, and stops early at a fault; the result is registered
// a root page outside the store skips the walk and gives an out-of-range result
// reset clears the controller and the root register; the table store is not cleared
// a result waits in the output register; the next item is taken while it waits,
// but a walk that ends while that register is still full holds until it drains

module four_level_page_walk_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,

  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  fplw_pkg::in_item_t           in_data_i,

  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output fplw_pkg::out_item_t          out_data_o,

  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [fplw_pkg::APB_AW-1:0]   paddr,
  input  wire [fplw_pkg::APB_DW-1:0]   pwdata,
  output logic [fplw_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import fplw_pkg::*;

  logic [ROOT_W-1:0] root_q;
  logic              reg_idx;
  logic              cfg_wr;
  ctrl_cmd_t         cmd;
  ctrl_stat_t        stat;

  // configuration port: zero wait states, register index from the word address
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_wr && (reg_idx == REG_ROOT)) begin
      root_q <= pwdata[ROOT_W-1:0];
    end
  end

  // writes beyond the register list are dropped and read back as zero
  always_comb begin
    if (reg_idx == REG_ROOT) begin
      prdata = APB_DW'(root_q);
    end else begin
      prdata = '0;
    end
  end

  // walk sequencer
  fplw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // table store, walk registers and result register
  fplw_datapath u_datapath (
    .clk_i       (clk_i),
    .in_data_i   (in_data_i),
    .root_page_i (root_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/fplw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fplw_datapath (
  input  wire                         clk_i,
  input  fplw_pkg::in_item_t          in_data_i,
  input  wire [fplw_pkg::ROOT_W-1:0]  root_page_i,
  input  fplw_pkg::ctrl_cmd_t         cmd_i,
  output fplw_pkg::ctrl_stat_t        stat_o,
  output fplw_pkg::out_item_t         out_data_o
);
  import fplw_pkg::*;

  localparam int SHIFT_L0 = 39;
  localparam int SHIFT_L1 = 30;
  localparam int SHIFT_L2 = 21;
  localparam int SHIFT_L3 = 12;

  function automatic logic [IDX_W-1:0] idx_of(input logic [VA_W-1:0] va,
                                              input logic [1:0] lvl);
    logic [VA_W-1:0] sh;
    begin
      case (lvl)
        2'd0:    sh = va >> SHIFT_L0;
        2'd1:    sh = va >> SHIFT_L1;
        2'd2:    sh = va >> SHIFT_L2;
        default: sh = va >> SHIFT_L3;
      endcase
      return sh[IDX_W-1:0];
    end
  endfunction

  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic [VA_W-1:0]   va_q;
  logic [1:0]        level_q;
  out_item_t         out_q;

  logic [31:0]       widx_ext;
  logic [31:0]       root_ext;
  logic              wr_ok;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              re;
  logic [39:0]       frame;
  logic              present;
  logic              frame_oob;
  logic [1:0]        level_nxt;

  assign widx_ext  = 32'(in_data_i.word_index);
  assign root_ext  = 32'(root_page_i);
  assign wr_ok     = cmd_i.write_en && (widx_ext < 32'(STORE_WORDS));
  assign waddr     = widx_ext[ADDR_W-1:0];

  assign frame     = rdata_q[51:12];
  assign present   = rdata_q[0];
  assign frame_oob = 64'(frame) >= 64'(TABLE_PAGES);
  assign level_nxt = level_q + 2'd1;

  assign re = cmd_i.start | cmd_i.step;

  // top read comes straight from the accepted item, later ones from the entry just read
  always_comb begin
    if (cmd_i.start) begin
      raddr = {root_ext[PAGE_W-1:0], idx_of(in_data_i.virtual_address, LVL_TOP)};
    end else begin
      raddr = {frame[PAGE_W-1:0], idx_of(va_q, level_nxt)};
    end
  end

  assign stat_o.root_oob  = root_ext >= 32'(TABLE_PAGES);
  assign stat_o.walk_done = !present || (level_q == LVL_LEAF) || frame_oob;

  // table store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[waddr] <= in_data_i.write_data;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      va_q    <= in_data_i.virtual_address;
      level_q <= LVL_TOP;
    end else if (cmd_i.step) begin
      level_q <= level_nxt;
    end

    if (cmd_i.load_root) begin
      out_q.physical_address <= '0;
      out_q.status           <= ST_OUT_OF_RANGE;
      out_q.fault_level      <= LVL_TOP;
    end else if (cmd_i.load_walk) begin
      if (!present) begin
        out_q.physical_address <= '0;
        out_q.status           <= ST_NOT_PRESENT;
        out_q.fault_level      <= level_q;
      end else if (level_q != LVL_LEAF) begin
        out_q.physical_address <= '0;
        out_q.status           <= ST_OUT_OF_RANGE;
        out_q.fault_level      <= level_q;
      end else begin
        out_q.physical_address <= {frame, va_q[OFFSET_W-1:0]};
        out_q.status           <= ST_MAPPED;
        out_q.fault_level      <= LVL_LEAF;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: rtl/fplw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fplw_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_command_i,
  output logic                  in_ready_o,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  input  fplw_pkg::ctrl_stat_t  stat_i,
  output fplw_pkg::ctrl_cmd_t   cmd_o
);
  import fplw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ROOT_FLT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == CMD_WRITE) begin
            cmd_o.write_en = 1'b1;
          end else if (stat_i.root_oob) begin
            state_d = S_ROOT_FLT;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) begin
          if (out_free) begin
            cmd_o.load_walk = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_ROOT_FLT: begin
        if (out_free) begin
          cmd_o.load_root = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_walk || cmd_o.load_root) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// bench for the four-level page walk unit
// - table word writes and translate requests go through a pending queue into the driver
// - every translate accepted on the input is walked over a local copy of the table store
//   and the outcome is queued; the monitor compares each result transfer field by field
// - translate addresses are steered so that a walk only reads table words that were
//   written before, since the block leaves its store undefined after reset
// - the root register is rewritten between phases, only once the block has gone quiet

module tb_top;
  import fplw_pkg::*;

  localparam int          IDLE_PCT     = 11;      // idle cycles per hundred on each side
  localparam int          PHASES       = 4;
  localparam int          PHASE_ITEMS  = 200;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          HOLD_AT      = 180;     // result count that starts the long hold
  localparam int          HOLD_CYCLES  = 200;
  localparam int          LIMIT_CYCLES = 200000;
  localparam logic [63:0] HUGE_BIT     = 64'h80;  // page size bit, not interpreted

  localparam logic [APB_AW-1:0] ROOT_ADDR = APB_AW'(4 * REG_ROOT);

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // item channel
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;

  // result channel
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  four_level_page_walk_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // items waiting for the driver, and walk outcomes waiting for the monitor
  in_item_t  cmd_queue[$];
  out_item_t expected_walks[$];
  out_item_t oldest_walk;

  // table store as seen at the input of the block, updated on each accepted write
  logic [WORD_W-1:0] table_mirror [STORE_WORDS];
  logic [ROOT_W-1:0] root_page = '0;

  // planning copy of the store, ahead of the block by whatever sits in cmd_queue
  logic [WORD_W-1:0] plan_table   [STORE_WORDS];
  bit                plan_written [STORE_WORDS];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  steady       = 1'b0;   // no idling on either side
  int  cycle_count  = 0;

  // four-level walk over the mirrored store
  function automatic out_item_t walk_table(logic [VA_W-1:0] va);
    out_item_t         res;
    logic [WORD_W-1:0] entry;
    logic [39:0]       frame;
    int unsigned       page;
    int                lvl;
    res   = '0;
    frame = '0;
    page  = 32'(root_page);
    if (page >= TABLE_PAGES) begin
      res.status      = ST_OUT_OF_RANGE;
      res.fault_level = LVL_TOP;
      return res;
    end
    for (lvl = 0; lvl < 4; lvl++) begin
      entry = table_mirror[page * ENTRIES_PER_TABLE + va[39 - 9 * lvl +: 9]];
      if (!entry[0]) begin
        res.status      = ST_NOT_PRESENT;
        res.fault_level = lvl[1:0];
        return res;
      end
      frame = entry[51:12];
      // only table frames are range checked, the leaf frame names a data page
      if (lvl < 3) begin
        if (frame >= TABLE_PAGES) begin
          res.status      = ST_OUT_OF_RANGE;
          res.fault_level = lvl[1:0];
          return res;
        end
        page = 32'(frame);
      end
    end
    res.physical_address = {frame, va[11:0]};
    res.status           = ST_MAPPED;
    res.fault_level      = LVL_LEAF;
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] table_entry(logic present, logic [39:0] frame);
    return {12'h000, frame, 11'h000, present};
  endfunction

  function automatic logic [VA_W-1:0] build_va(logic [8:0] i0, logic [8:0] i1,
                                               logic [8:0] i2, logic [8:0] i3,
                                               logic [11:0] offset);
    logic [VA_W-1:0] va;
    va       = {$urandom, $urandom};
    va[47:0] = {i0, i1, i2, i3, offset};
    return va;
  endfunction

  // a written entry of the given table page, random where possible; unwritten if the page has none
  function automatic int unsigned pick_entry(int unsigned page);
    int unsigned idx;
    int          n;
    idx = 0;
    for (n = 0; n < 8; n++) begin
      idx = $urandom_range(ENTRIES_PER_TABLE - 1);
      if (plan_written[page * ENTRIES_PER_TABLE + idx]) return idx;
    end
    for (n = 0; n < ENTRIES_PER_TABLE; n++) begin
      idx = (idx + 1) % ENTRIES_PER_TABLE;
      if (plan_written[page * ENTRIES_PER_TABLE + idx]) return idx;
    end
    return idx;
  endfunction

  // random address whose walk reads written entries only; levels past a fault stay random
  function automatic logic [VA_W-1:0] plan_walk_va();
    logic [VA_W-1:0]   va;
    logic [WORD_W-1:0] entry;
    int unsigned       page;
    int unsigned       idx;
    int                lvl;
    va   = {$urandom, $urandom};
    page = 32'(root_page);
    for (lvl = 0; lvl < 4; lvl++) begin
      idx = pick_entry(page);
      va[39 - 9 * lvl +: 9] = idx[8:0];
      entry = plan_table[page * ENTRIES_PER_TABLE + idx];
      if (!entry[0] || (lvl < 3 && entry[51:12] >= TABLE_PAGES)) break;
      page = 32'(entry[51:12]);
    end
    return va;
  endfunction

  task automatic queue_write(logic [WIDX_W-1:0] widx, logic [WORD_W-1:0] data);
    in_item_t it;
    it.command         = CMD_WRITE;
    it.word_index      = widx;
    it.write_data      = data;
    it.virtual_address = {$urandom, $urandom};
    plan_table[widx]   = data;
    plan_written[widx] = 1'b1;
    cmd_queue.push_back(it);
  endtask

  task automatic queue_translate(logic [VA_W-1:0] va);
    in_item_t it;
    it.command         = CMD_TRANSLATE;
    it.word_index      = WIDX_W'($urandom);
    it.write_data      = {$urandom, $urandom};
    it.virtual_address = va;
    cmd_queue.push_back(it);
  endtask

  // mostly well-formed entries that point at table pages, the rest plain noise
  task automatic queue_random_write();
    logic [WORD_W-1:0] data;
    data = {$urandom, $urandom};
    if ($urandom_range(99) < 85) begin
      data[0] = ($urandom_range(9) != 0);
      if ($urandom_range(99) < 88) data[51:12] = 40'($urandom_range(TABLE_PAGES - 1));
    end
    queue_write(WIDX_W'($urandom_range(STORE_WORDS - 1)), data);
  endtask

  // setup cycle, then access cycle; the register takes the value at the access edge
  task automatic write_root(logic [ROOT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOT_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    root_page = value;
  endtask

  // block quiet: everything accepted, every outcome seen, trailing write settled
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || in_valid || expected_walks.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // driver: predicts on each accepted transfer, then offers the next item or idles
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      if (in_data.command == CMD_WRITE) begin
        if (in_data.word_index < STORE_WORDS) table_mirror[in_data.word_index] = in_data.write_data;
      end else begin
        expected_walks.push_back(walk_table(in_data.virtual_address));
      end
    end
    if (!in_valid || in_ready) begin
      if (rst_ni && cmd_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= cmd_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result transfer and drives out_ready, with one long hold
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (expected_walks.size() == 0) begin
        $display("%0t: result expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        oldest_walk = expected_walks.pop_front();
        if (out_data.physical_address !== oldest_walk.physical_address) begin
          $display("%0t: physical_address expected %h got %h", $time,
                   oldest_walk.physical_address, out_data.physical_address);
          mismatches++;
        end
        if (out_data.status !== oldest_walk.status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   oldest_walk.status, out_data.status);
          mismatches++;
        end
        if (out_data.fault_level !== oldest_walk.fault_level) begin
          $display("%0t: fault_level expected %0d got %0d", $time,
                   oldest_walk.fault_level, out_data.fault_level);
          mismatches++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (results_seen >= HOLD_AT && !hold_done) begin
      // long back-pressure so the block fills and drops in_ready
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [ROOT_W-1:0] next_root;
    int                ph;
    int                n;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_root('0);
    @(negedge clk_i);

    // directed tables: page 0 is the root, a chain 0 -> 1 -> 2 -> 3 ends in an all-ones leaf
    queue_write(WIDX_W'(0 * ENTRIES_PER_TABLE + 0), table_entry(1'b1, 40'd1));
    queue_write(WIDX_W'(0 * ENTRIES_PER_TABLE + 1), table_entry(1'b1, '1));
    queue_write(WIDX_W'(0 * ENTRIES_PER_TABLE + 2), table_entry(1'b1, 40'd4));
    queue_write(WIDX_W'(0 * ENTRIES_PER_TABLE + 3), table_entry(1'b1, 40'd7));
    queue_write(WIDX_W'(0 * ENTRIES_PER_TABLE + 4), table_entry(1'b1, 40'd6));
    queue_write(WIDX_W'(0 * ENTRIES_PER_TABLE + 511), '0);
    queue_write(WIDX_W'(1 * ENTRIES_PER_TABLE + 0), table_entry(1'b1, 40'd2));
    queue_write(WIDX_W'(1 * ENTRIES_PER_TABLE + 1), table_entry(1'b1, 40'd5));
    queue_write(WIDX_W'(2 * ENTRIES_PER_TABLE + 0), table_entry(1'b1, 40'd3));
    queue_write(WIDX_W'(3 * ENTRIES_PER_TABLE + 0), '1);
    queue_write(WIDX_W'(3 * ENTRIES_PER_TABLE + 5), ~64'h1);  // everything set but present
    queue_write(WIDX_W'(4 * ENTRIES_PER_TABLE + 511), '0);
    // one past the end
    queue_write(WIDX_W'(5 * ENTRIES_PER_TABLE + 511), table_entry(1'b1, 40'(TABLE_PAGES)));
    queue_write(WIDX_W'(6 * ENTRIES_PER_TABLE + 511), '1);
    // last word
    queue_write(WIDX_W'(7 * ENTRIES_PER_TABLE + 511), table_entry(1'b1, 40'd0) | HUGE_BIT);

    // mapped through the chain, leaf frame out of store is still a mapping
    queue_translate(build_va(0, 0, 0, 0, 12'hFFF));
    queue_translate('0);
    // not present at levels 0, 1 and 3, out of range at levels 0, 1 and 2
    queue_translate(build_va(511, 9'($urandom), 9'($urandom), 9'($urandom), 12'($urandom)));
    queue_translate(build_va(1, 9'($urandom), 9'($urandom), 9'($urandom), 12'($urandom)));
    queue_translate(build_va(2, 511, 9'($urandom), 9'($urandom), 12'($urandom)));
    queue_translate(build_va(4, 511, 9'($urandom), 9'($urandom), 12'($urandom)));
    queue_translate(build_va(0, 1, 511, 9'($urandom), 12'($urandom)));
    queue_translate(build_va(0, 0, 0, 5, 12'($urandom)));
    // page size bit on a table entry is walked like any other entry
    queue_translate(build_va(3, 511, 0, 0, 12'($urandom)));
    wait_quiet();

    // random phases under different roots, the second one without idling
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       next_root = '1;
        1:       next_root = ROOT_W'($urandom_range(TABLE_PAGES - 2, 1));
        2:       next_root = '0;
        default: next_root = '1;
      endcase
      steady = (ph == 1);
      write_root(next_root);
      @(negedge clk_i);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 40) queue_random_write();
        else queue_translate(plan_walk_va());
      end
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
